// ----- rtl/sset_pkg.sv -----
// Shared widths, command and status codes, and defaults for the sparse set block.
`default_nettype none

package sset_pkg;

   // Field widths of the channels and the capacity register
   localparam int CMD_W    = 3;
   localparam int ITEM_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ELEM_W   = 8;
   localparam int SIZE_W   = 9;
   localparam int CAP_W    = 9;

   // Default sizing
   localparam int DEF_MAX_ELEMENTS = 256;
   localparam int DEF_UNDO_DEPTH   = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT_VAL = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE_VAL = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INSERT_POS = 3'd2;
   localparam logic [CMD_W-1:0] CMD_REMOVE_POS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_COMMIT     = 3'd4;
   localparam logic [CMD_W-1:0] CMD_ROLLBACK   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd6;
   localparam logic [CMD_W-1:0] CMD_READ_POS   = 3'd7;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_DUP   = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/sset_req_if.sv -----
// Request channel interface: command and operand with valid/ready.
`default_nettype none

interface sset_req_if;
   import sset_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  cmd;
   logic [ITEM_W-1:0] item;

   modport source (output valid, cmd, item, input ready);
   modport sink   (input valid, cmd, item, output ready);
endinterface

`default_nettype wire

// ----- rtl/sset_rsp_if.sv -----
// Response channel interface: status, membership, element and set size with valid/ready.
`default_nettype none

interface sset_rsp_if;
   import sset_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                present;
   logic [ELEM_W-1:0]   element;
   logic [SIZE_W-1:0]   set_size;

   modport source (output valid, status, present, element, set_size, input ready);
   modport sink   (input valid, status, present, element, set_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/sparse_set_with_undo_unit.sv -----
// Top level: sparse set over a permutation pair with an undo log of swaps.
//
//   port        dir   handshake        payload
//   ----------  ----  ---------------  ---------------------------------------
//   req_if      in    valid / ready    cmd[2:0], item[7:0]
//   rsp_if      out   valid / ready    status[1:0], present, element[7:0],
//                                      set_size[8:0]
//   csr_*       in    csr_wr_en        csr_wr_data[8:0] = capacity in use
//
// Commit, queries and rejected commands answer from S_LOOK; an insert or remove goes
// on through S_WR1 and S_WR2, a rollback through S_LOGRD, S_RDQ, S_WR1 and S_WR2 for
// each logged swap, each swap being a read-modify-write on the two single-port-read
// map RAMs. Reset and each capacity write start a clearing pass over the capacity
// in use that rewrites both maps to identity; no item is taken meanwhile.
// A waiting result holds off the input; the next item goes in as it leaves.
`default_nettype none

module sparse_set_with_undo_unit #(
   parameter int MAX_ELEMENTS = sset_pkg::DEF_MAX_ELEMENTS,
   parameter int UNDO_DEPTH   = sset_pkg::DEF_UNDO_DEPTH
) (
   input  logic                       clock,
   input  logic                       reset,
   sset_req_if.sink                   req_if,
   sset_rsp_if.source                 rsp_if,
   input  logic                       csr_wr_en,
   input  logic [sset_pkg::CAP_W-1:0] csr_wr_data
);
   import sset_pkg::*;

   // Index of a position or value, member count, undo count, log address
   localparam int IDX_W  = $clog2(MAX_ELEMENTS);
   localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
   localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int UCNT_W = $clog2(UNDO_DEPTH + 1);
   localparam int LOG_AW = (UNDO_DEPTH > 1) ? $clog2(UNDO_DEPTH) : 1;
   localparam int LOG_W  = 2 * IDX_W + 1;

   localparam logic [CMP_W-1:0]  MAX_CAP   = CMP_W'(MAX_ELEMENTS);
   localparam logic [CMP_W-1:0]  RESET_CAP = CMP_W'((MAX_ELEMENTS < 256) ? MAX_ELEMENTS : 256);
   localparam logic [UCNT_W-1:0] LOG_LIMIT = UCNT_W'(UNDO_DEPTH);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,   // sweep both maps to identity
      S_IDLE  = 7'b0000010,   // wait for an item
      S_LOOK  = 7'b0000100,   // map lookups back, decide
      S_LOGRD = 7'b0001000,   // log entry back, read value at p
      S_RDQ   = 7'b0010000,   // value at p back, read value at q
      S_WR1   = 7'b0100000,   // write p side of the swap
      S_WR2   = 7'b1000000    // write q side, log / count update
   } state_type;

   state_type         state_ff, state_in;
   logic [CMP_W-1:0]  cap_ff, cap_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [UCNT_W-1:0] ucnt_ff, ucnt_in;
   logic [IDX_W-1:0]  clr_ff, clr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Per-item working registers
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [ITEM_W-1:0] item_ff, item_in;
   logic [IDX_W-1:0]  p_ff, p_in;
   logic [IDX_W-1:0]  q_ff, q_in;
   logic [IDX_W-1:0]  a_ff, a_in;
   logic              grew_ff, grew_in;
   logic              undo_ff, undo_in;

   // Result registers
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic                rsp_present_ff, rsp_present_in;
   logic [ELEM_W-1:0]   rsp_element_ff, rsp_element_in;
   logic [SIZE_W-1:0]   rsp_size_ff, rsp_size_in;

   // RAM ports
   logic              vap_wr_en, pov_wr_en, log_wr_en;
   logic [IDX_W-1:0]  vap_wr_addr, vap_wr_data, vap_rd_addr, vap_rdata;
   logic [IDX_W-1:0]  pov_wr_addr, pov_wr_data, pov_rd_addr, pov_rdata;
   logic [LOG_AW-1:0] log_wr_addr, log_rd_addr;
   logic [LOG_W-1:0]  log_wr_data, log_rdata;

   // Decode helpers
   logic                accept;
   logic                inserting;
   logic                by_pos;
   logic                out_of_range;
   logic                log_full;
   logic [IDX_W-1:0]    pos_w;
   logic [UCNT_W-1:0]   ucnt_dec;
   logic [CMP_W-1:0]    csr_cap;
   logic                finish;
   logic [STATUS_W-1:0] fin_status;
   logic                fin_present;
   logic [ELEM_W-1:0]   fin_element;

   sset_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_vap_ram (
      .clock   (clock),
      .wr_en   (vap_wr_en),
      .wr_addr (vap_wr_addr),
      .wr_data (vap_wr_data),
      .rd_addr (vap_rd_addr),
      .rd_data (vap_rdata)
   );

   sset_ram #(.WIDTH(IDX_W), .DEPTH(MAX_ELEMENTS)) u_pov_ram (
      .clock   (clock),
      .wr_en   (pov_wr_en),
      .wr_addr (pov_wr_addr),
      .wr_data (pov_wr_data),
      .rd_addr (pov_rd_addr),
      .rd_data (pov_rdata)
   );

   sset_ram #(.WIDTH(LOG_W), .DEPTH(UNDO_DEPTH)) u_log_ram (
      .clock   (clock),
      .wr_en   (log_wr_en),
      .wr_addr (log_wr_addr),
      .wr_data (log_wr_data),
      .rd_addr (log_rd_addr),
      .rd_data (log_rdata)
   );

   assign req_if.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign accept       = req_if.valid && req_if.ready;

   assign inserting    = (cmd_ff == CMD_INSERT_VAL) || (cmd_ff == CMD_INSERT_POS);
   assign by_pos       = (cmd_ff == CMD_INSERT_POS) || (cmd_ff == CMD_REMOVE_POS);
   assign out_of_range = CMP_W'(item_ff) >= cap_ff;
   assign log_full     = ucnt_ff == LOG_LIMIT;
   assign pos_w        = by_pos ? IDX_W'(item_ff) : pov_rdata;
   assign ucnt_dec     = ucnt_ff - 1'b1;

   // Capacity write: zero acts as one, anything above the map size saturates
   always_comb begin
      csr_cap = CMP_W'(csr_wr_data);
      if (csr_cap == '0) begin
         csr_cap = CMP_W'(1);
      end else if (csr_cap > MAX_CAP) begin
         csr_cap = MAX_CAP;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cap_in         = cap_ff;
      count_in       = count_ff;
      ucnt_in        = ucnt_ff;
      clr_in         = clr_ff;
      cmd_in         = cmd_ff;
      item_in        = item_ff;
      p_in           = p_ff;
      q_in           = q_ff;
      a_in           = a_ff;
      grew_in        = grew_ff;
      undo_in        = undo_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_present_in = rsp_present_ff;
      rsp_element_in = rsp_element_ff;
      rsp_size_in    = rsp_size_ff;

      // Lookups at the incoming operand run every idle cycle
      vap_wr_en   = 1'b0;
      vap_wr_addr = '0;
      vap_wr_data = '0;
      vap_rd_addr = IDX_W'(req_if.item);
      pov_wr_en   = 1'b0;
      pov_wr_addr = '0;
      pov_wr_data = '0;
      pov_rd_addr = IDX_W'(req_if.item);
      log_wr_en   = 1'b0;
      log_wr_addr = ucnt_ff[LOG_AW-1:0];
      log_wr_data = {grew_ff, p_ff, q_ff};
      log_rd_addr = ucnt_dec[LOG_AW-1:0];

      finish      = 1'b0;
      fin_status  = STAT_OK;
      fin_present = 1'b0;
      fin_element = '0;

      unique case (state_ff)
         S_CLEAR: begin
            vap_wr_en   = 1'b1;
            vap_wr_addr = clr_ff;
            vap_wr_data = clr_ff;
            pov_wr_en   = 1'b1;
            pov_wr_addr = clr_ff;
            pov_wr_data = clr_ff;
            if (CMP_W'(clr_ff) == cap_ff - 1'b1) begin
               state_in = S_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end

         S_IDLE: begin
            if (accept) begin
               cmd_in   = req_if.cmd;
               item_in  = req_if.item;
               state_in = S_LOOK;
            end
         end

         S_LOOK: begin
            if (cmd_ff == CMD_COMMIT) begin
               ucnt_in = '0;
               finish  = 1'b1;
            end else if (cmd_ff == CMD_ROLLBACK) begin
               if (ucnt_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  ucnt_in  = ucnt_dec;
                  undo_in  = 1'b1;
                  state_in = S_LOGRD;
               end
            end else if (out_of_range) begin
               fin_status = STAT_RANGE;
               finish     = 1'b1;
            end else begin
               unique case (cmd_ff) inside
                  CMD_CONTAINS: begin
                     fin_present = CNT_W'(pov_rdata) < count_ff;
                     finish      = 1'b1;
                  end
                  CMD_READ_POS: begin
                     fin_element = ELEM_W'(vap_rdata);
                     finish      = 1'b1;
                  end
                  CMD_INSERT_VAL, CMD_REMOVE_VAL, CMD_INSERT_POS, CMD_REMOVE_POS: begin
                     if (inserting ? (CNT_W'(pos_w) < count_ff)
                                   : (CNT_W'(pos_w) >= count_ff)) begin
                        fin_status = STAT_DUP;
                        finish     = 1'b1;
                     end else if (log_full) begin
                        fin_status = STAT_FULL;
                        finish     = 1'b1;
                     end else begin
                        // value at pos is the operand itself for value commands
                        p_in        = pos_w;
                        q_in        = inserting ? IDX_W'(count_ff) : IDX_W'(count_ff - 1'b1);
                        a_in        = by_pos ? vap_rdata : IDX_W'(item_ff);
                        grew_in     = inserting;
                        undo_in     = 1'b0;
                        vap_rd_addr = q_in;
                        state_in    = S_WR1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end

         S_LOGRD: begin
            {grew_in, p_in, q_in} = log_rdata;
            vap_rd_addr = p_in;
            state_in    = S_RDQ;
         end

         S_RDQ: begin
            a_in        = vap_rdata;
            vap_rd_addr = q_ff;
            state_in    = S_WR1;
         end

         S_WR1: begin
            // vap_rdata holds the value at q
            vap_wr_en   = 1'b1;
            vap_wr_addr = p_ff;
            vap_wr_data = vap_rdata;
            pov_wr_en   = 1'b1;
            pov_wr_addr = vap_rdata;
            pov_wr_data = p_ff;
            state_in    = S_WR2;
         end

         S_WR2: begin
            vap_wr_en   = 1'b1;
            vap_wr_addr = q_ff;
            vap_wr_data = a_ff;
            pov_wr_en   = 1'b1;
            pov_wr_addr = a_ff;
            pov_wr_data = q_ff;
            if (undo_ff) begin
               if (grew_ff) begin
                  if (count_ff != '0) begin
                     count_in = count_ff - 1'b1;
                  end
               end else begin
                  count_in = count_ff + 1'b1;
               end
               if (ucnt_ff != '0) begin
                  ucnt_in  = ucnt_dec;
                  state_in = S_LOGRD;
               end else begin
                  finish = 1'b1;
               end
            end else begin
               log_wr_en = 1'b1;
               ucnt_in   = ucnt_ff + 1'b1;
               count_in  = grew_ff ? count_ff + 1'b1 : count_ff - 1'b1;
               finish    = 1'b1;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = fin_status;
         rsp_present_in = fin_present;
         rsp_element_in = fin_element;
         rsp_size_in    = SIZE_W'(count_in);
         state_in       = S_IDLE;
      end

      // Capacity write resets capacity, member count, undo count and sweep index and restarts the sweep
      if (csr_wr_en) begin
         cap_in   = csr_cap;
         count_in = '0;
         ucnt_in  = '0;
         clr_in   = '0;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         cap_ff       <= RESET_CAP;
         count_ff     <= '0;
         ucnt_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         ucnt_ff      <= ucnt_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      item_ff        <= item_in;
      p_ff           <= p_in;
      q_ff           <= q_in;
      a_ff           <= a_in;
      grew_ff        <= grew_in;
      undo_ff        <= undo_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_present_ff <= rsp_present_in;
      rsp_element_ff <= rsp_element_in;
      rsp_size_ff    <= rsp_size_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.status   = rsp_status_ff;
   assign rsp_if.present  = rsp_present_ff;
   assign rsp_if.element  = rsp_element_ff;
   assign rsp_if.set_size = rsp_size_ff;

endmodule

`default_nettype wire

// ----- rtl/sset_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module sset_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- bench/tb_sparse_set_with_undo_unit.sv -----
// Self-checking bench for the sparse set with undo log: shadow set, random traffic, stalls.
`timescale 1ns / 100ps

module tb_sparse_set_with_undo_unit;
   import sset_pkg::*;

   localparam int MAX_ELEMS   = DEF_MAX_ELEMENTS;
   localparam int LOG_DEPTH   = DEF_UNDO_DEPTH;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int HOLD_CYCLES = 300;

   // One command on the request channel
   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ITEM_W-1:0] operand;
   } set_cmd_type;

   // One answer on the response channel
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                present;
      logic [ELEM_W-1:0]   element;
      logic [SIZE_W-1:0]   set_size;
   } set_answer_type;

   // One logged swap: entry position, boundary position, and whether it grew the set
   typedef struct {
      int spot;
      int boundary;
      bit grew;
   } swap_rec_type;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [CAP_W-1:0]  csr_wr_data = '0;

   sset_req_if req_if ();
   sset_rsp_if rsp_if ();

   sparse_set_with_undo_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow copy of the set: permutation, inverse, size, swap log
   // ------------------------------------------------------------------
   logic [ELEM_W-1:0] shadow_val_at [MAX_ELEMS];
   logic [ELEM_W-1:0] shadow_pos_of [MAX_ELEMS];
   int                shadow_size;
   int                shadow_cap;
   swap_rec_type      swap_log [LOG_DEPTH];
   int                swap_log_depth;

   // Run statistics for the summary
   int status_tally [4];
   int rollbacks_done;
   int largest_set;
   int cap_writes;
   int cmds_accepted;

   // Capacity write: clamp, then identity maps, empty set, empty log
   function automatic void shadow_configure(input logic [CAP_W-1:0] value);
      int c;
      c = int'(value);
      if (c == 0) c = 1;
      if (c > MAX_ELEMS) c = MAX_ELEMS;
      shadow_cap = c;
      for (int k = 0; k < MAX_ELEMS; k++) begin
         shadow_val_at[k] = ELEM_W'(k);
         shadow_pos_of[k] = ELEM_W'(k);
      end
      shadow_size    = 0;
      swap_log_depth = 0;
   endfunction

   function automatic void swap_shadow(input int p, input int q);
      logic [ELEM_W-1:0] a, b;
      a = shadow_val_at[p];
      b = shadow_val_at[q];
      shadow_val_at[p] = b;
      shadow_val_at[q] = a;
      shadow_pos_of[a] = ELEM_W'(q);
      shadow_pos_of[b] = ELEM_W'(p);
   endfunction

   // Undo every logged swap, newest first, moving the size back with each
   function automatic void unwind_swaps();
      swap_rec_type e;
      while (swap_log_depth > 0) begin
         swap_log_depth--;
         e = swap_log[swap_log_depth];
         swap_shadow(e.spot, e.boundary);
         if (e.grew) begin
            if (shadow_size > 0) shadow_size--;
         end else begin
            shadow_size++;
         end
      end
   endfunction

   // Apply one accepted command to the shadow set and return the answer it must give
   function automatic set_answer_type apply_to_shadow_set(input logic [CMD_W-1:0]  cmd,
                                                          input logic [ITEM_W-1:0] operand);
      set_answer_type r;
      int             pos;
      bit             grow;
      r = '0;
      if (cmd == CMD_COMMIT) begin
         swap_log_depth = 0;
      end else if (cmd == CMD_ROLLBACK) begin
         unwind_swaps();
         rollbacks_done++;
      end else if (int'(operand) >= shadow_cap) begin
         r.status = STAT_RANGE;
      end else if (cmd == CMD_CONTAINS) begin
         r.present = (int'(shadow_pos_of[operand]) < shadow_size);
      end else if (cmd == CMD_READ_POS) begin
         r.element = shadow_val_at[operand];
      end else begin
         grow = (cmd == CMD_INSERT_VAL || cmd == CMD_INSERT_POS);
         if (cmd == CMD_INSERT_VAL || cmd == CMD_REMOVE_VAL)
            pos = int'(shadow_pos_of[operand]);
         else
            pos = int'(operand);
         if (grow ? (pos < shadow_size) : (pos >= shadow_size)) begin
            r.status = STAT_DUP;
         end else if (swap_log_depth >= LOG_DEPTH) begin
            r.status = STAT_FULL;
         end else if (grow) begin
            swap_shadow(pos, shadow_size);
            swap_log[swap_log_depth] = '{spot: pos, boundary: shadow_size, grew: 1'b1};
            swap_log_depth++;
            shadow_size++;
         end else begin
            shadow_size--;
            swap_shadow(pos, shadow_size);
            swap_log[swap_log_depth] = '{spot: pos, boundary: shadow_size, grew: 1'b0};
            swap_log_depth++;
         end
      end
      r.set_size = SIZE_W'(shadow_size);
      status_tally[r.status]++;
      if (shadow_size > largest_set) largest_set = shadow_size;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Queues and handshake bookkeeping
   // ------------------------------------------------------------------
   set_cmd_type    cmd_queue[$];      // commands not yet offered
   set_answer_type answer_queue[$];   // answers owed by the block, oldest first

   int req_offered, req_taken;
   int rsp_taken, rsp_seen;
   int send_gap, send_calm;
   int recv_wait, recv_calm;
   int hold_orders, hold_served, hold_left;
   int fail_count;
   int cycles_run;

   // Per-item random wait, with occasional stretches of back-to-back traffic
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) begin
         calm = $urandom_range(20, 80);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   function automatic void note_mismatch(input string field,
                                         input logic [8:0] want, input logic [8:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
      end
   endfunction

   // ------------------------------------------------------------------
   // Request driver: one item at a time from cmd_queue, changes on the falling edge.
   // valid drops only after the offered item has been taken and nothing follows at once.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : request_driver
      set_cmd_type nxt;
      logic        offer;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         offer = req_if.valid;
         if (offer && req_taken == req_offered) offer = 1'b0;
         if (!offer) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (cmd_queue.size() != 0) begin
               nxt = cmd_queue.pop_front();
               req_if.cmd  <= nxt.cmd;
               req_if.item <= nxt.operand;
               req_offered++;
               send_gap = draw_wait(send_calm);
               offer    = 1'b1;
            end
         end
         req_if.valid <= offer;
      end
   end

   // ------------------------------------------------------------------
   // Response receiver: random wait after every taken answer, plus long holds on order
   // so that the block backs up and stops taking requests.
   // ------------------------------------------------------------------
   always @(negedge clock) begin : response_receiver
      logic take;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_taken != rsp_seen) begin
            rsp_seen  = rsp_taken;
            recv_wait = draw_wait(recv_calm);
         end
         if (hold_orders != hold_served) begin
            hold_served = hold_orders;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            take = 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_if.ready <= take;
      end
   end

   // ------------------------------------------------------------------
   // Monitor on the rising edge. Answers are checked before the request taken at the
   // same edge is predicted, so a premature answer can never match its own request.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : channel_monitor
      set_answer_type got, want;
      cycles_run <= cycles_run + 1;
      if (!reset) begin
         if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            rsp_taken++;
            got = '{status: rsp_if.status, present: rsp_if.present,
                    element: rsp_if.element, set_size: rsp_if.set_size};
            if (answer_queue.size() == 0) begin
               fail_count++;
               $display("%0t: answer with none outstanding: expected nothing, got %h",
                        $time, got);
            end else begin
               want = answer_queue.pop_front();
               note_mismatch("status",   9'(want.status),  9'(got.status));
               note_mismatch("present",  9'(want.present), 9'(got.present));
               note_mismatch("element",  9'(want.element), 9'(got.element));
               note_mismatch("set_size", want.set_size,    got.set_size);
            end
         end
         if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
            req_taken++;
            cmds_accepted++;
            want = apply_to_shadow_set(req_if.cmd, req_if.item);
            answer_queue.insert(answer_queue.size(), want);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic void push_cmd(input logic [CMD_W-1:0] cmd, input int operand);
      set_cmd_type c;
      c = '{cmd: cmd, operand: ITEM_W'(operand)};
      cmd_queue.insert(cmd_queue.size(), c);
   endfunction

   // Command mix; the log-filling mix never commits and rarely rolls back
   function automatic logic [CMD_W-1:0] pick_cmd(input bit fill_log);
      int r;
      r = $urandom_range(0, 99);
      if (fill_log) begin
         if (r < 40) return CMD_INSERT_VAL;
         if (r < 55) return CMD_INSERT_POS;
         if (r < 68) return CMD_REMOVE_VAL;
         if (r < 79) return CMD_REMOVE_POS;
         if (r < 80) return CMD_ROLLBACK;
         if (r < 90) return CMD_CONTAINS;
         return CMD_READ_POS;
      end
      if (r < 25) return CMD_INSERT_VAL;
      if (r < 45) return CMD_REMOVE_VAL;
      if (r < 57) return CMD_INSERT_POS;
      if (r < 69) return CMD_REMOVE_POS;
      if (r < 75) return CMD_COMMIT;
      if (r < 81) return CMD_ROLLBACK;
      if (r < 91) return CMD_CONTAINS;
      return CMD_READ_POS;
   endfunction

   // Operands mostly inside the current capacity, some anywhere in the field
   function automatic void queue_random(input int count, input bit fill_log);
      int operand;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 9) == 0)
            operand = $urandom_range(0, (1 << ITEM_W) - 1);
         else
            operand = $urandom_range(0, shadow_cap - 1);
         push_cmd(pick_cmd(fill_log), operand);
      end
   endfunction

   // Block is idle once every command is taken and every answer is in
   task automatic wait_until_idle();
      while (cmd_queue.size() != 0 || req_if.valid !== 1'b0 || answer_queue.size() != 0)
         @(negedge clock);
   endtask

   // Capacity write between phases; the clearing pass that follows holds off requests
   task automatic write_capacity(input logic [CAP_W-1:0] value);
      wait_until_idle();
      repeat (4) @(negedge clock);
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      shadow_configure(value);
      cap_writes++;
   endtask

   // ------------------------------------------------------------------
   // Watchdog
   // ------------------------------------------------------------------
   initial begin : watchdog
      wait (cycles_run >= CYCLE_LIMIT);
      $display("%0t: timeout with %0d answers outstanding", $time, answer_queue.size());
      $display("CHECK FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin : stimulus
      req_if.valid = 1'b0;
      req_if.cmd   = CMD_COMMIT;
      req_if.item  = '0;
      rsp_if.ready = 1'b0;
      shadow_configure(CAP_W'(DEF_MAX_ELEMENTS));
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // Directed, full capacity after reset
      push_cmd(CMD_CONTAINS,   0);     // empty set
      push_cmd(CMD_READ_POS,   255);   // top position, not a member
      push_cmd(CMD_INSERT_VAL, 0);
      push_cmd(CMD_INSERT_VAL, 0);     // already present
      push_cmd(CMD_INSERT_VAL, 255);
      push_cmd(CMD_REMOVE_VAL, 7);     // absent
      push_cmd(CMD_INSERT_POS, 0);     // below the size
      push_cmd(CMD_INSERT_POS, 255);
      push_cmd(CMD_REMOVE_POS, 200);   // at or above the size
      push_cmd(CMD_REMOVE_POS, 0);
      push_cmd(CMD_CONTAINS,   255);
      push_cmd(CMD_COMMIT,     255);   // operand ignored
      push_cmd(CMD_INSERT_VAL, 128);
      push_cmd(CMD_REMOVE_VAL, 255);
      push_cmd(CMD_ROLLBACK,   170);   // operand ignored
      push_cmd(CMD_READ_POS,   1);

      // Directed, small capacity: operands out of range and at the top of the range
      write_capacity(9'd5);
      push_cmd(CMD_INSERT_VAL, 5);
      push_cmd(CMD_READ_POS,   255);
      push_cmd(CMD_INSERT_VAL, 4);
      push_cmd(CMD_CONTAINS,   4);
      push_cmd(CMD_REMOVE_POS, 4);     // above the size, inside capacity

      // Directed, smallest universe
      write_capacity(9'd1);
      push_cmd(CMD_INSERT_VAL, 0);
      push_cmd(CMD_INSERT_VAL, 0);
      push_cmd(CMD_CONTAINS,   1);
      push_cmd(CMD_REMOVE_POS, 0);
      push_cmd(CMD_ROLLBACK,   0);

      // Random phases. All-ones clamps to the full universe, zero acts as one.
      write_capacity(9'h1FF);
      hold_orders++;                   // long receiver hold while requests keep coming
      queue_random(500, 1'b0);

      write_capacity(9'd16);
      queue_random(400, 1'b0);

      // Few rollbacks and no commits: the log fills and refuses, full rollbacks follow
      write_capacity(9'd256);
      hold_orders++;
      queue_random(400, 1'b1);

      write_capacity(9'd2);
      queue_random(200, 1'b0);

      write_capacity(9'd0);
      queue_random(100, 1'b0);

      write_capacity(9'd73);
      queue_random(400, 1'b1);

      wait_until_idle();
      repeat (24) @(posedge clock);

      $display("Covered %0d commands over %0d capacity settings, %0d rollbacks, largest set %0d.",
               cmds_accepted, cap_writes + 1, rollbacks_done, largest_set);
      $display("Answers: %0d ok, %0d out of range, %0d present/absent, %0d log full.",
               status_tally[STAT_OK], status_tally[STAT_RANGE],
               status_tally[STAT_DUP], status_tally[STAT_FULL]);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
